>>> rtl/oal_pkg.sv
`default_nettype none
package oal_pkg;

  localparam int DEPTH      = 64;
  localparam int GROUP_SIZE = 8;
  localparam int GROUPS     = DEPTH / GROUP_SIZE;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int OFF_W      = $clog2(GROUP_SIZE);
  localparam int GRP_W      = $clog2(GROUPS);
  localparam int CNT_W      = 7;
  localparam int DATA_W     = 32;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_UPDATE = 3'd2;
  localparam logic [2:0] OP_FIND   = 3'd3;
  localparam logic [2:0] OP_READ   = 3'd4;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_FULL     = 3'd1;
  localparam logic [2:0] ST_EMPTY    = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic CAP_REG_SEL = 1'b0;

  typedef struct packed {
    logic [2:0]               opcode;
    logic [IDX_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [2:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic [IDX_W-1:0]         found_index;
    logic [CNT_W-1:0]         entry_count;
    logic signed [DATA_W-1:0] first_value;
    logic signed [DATA_W-1:0] last_value;
  } rsp_t;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_INS,
    CMD_DEL,
    CMD_WR
  } cell_cmd_t;

  // Broadcast to every cell of the row.
  typedef struct packed {
    cell_cmd_t         cmd;
    logic [IDX_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic [CNT_W-1:0]  count;
  } cell_ctrl_t;

  typedef struct packed {
    logic              find_hit;
    logic              rd_hit;
    logic              last_hit;
    logic [DATA_W-1:0] entry;
  } cell_flags_t;

  typedef struct packed {
    logic              found;
    logic [OFF_W-1:0]  off;
    logic [DATA_W-1:0] rd_val;
    logic [DATA_W-1:0] last_val;
  } grp_res_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_FIN
  } state_t;

endpackage
`default_nettype wire

>>> rtl/oal_cell.sv
`default_nettype none
module oal_cell (
  input  wire logic                        clk,
  input  wire logic [oal_pkg::IDX_W-1:0]   idx,
  input  wire oal_pkg::cell_ctrl_t         ctrl,
  input  wire logic [oal_pkg::DATA_W-1:0]  left_entry,
  input  wire logic [oal_pkg::DATA_W-1:0]  right_entry,
  output logic [oal_pkg::DATA_W-1:0]       entry,
  output oal_pkg::cell_flags_t             flags
);
  import oal_pkg::*;

  logic             at_pos;
  logic             below;
  logic [CNT_W-1:0] idx_ext;

  assign idx_ext = CNT_W'(idx);
  assign at_pos  = (idx == ctrl.pos);
  assign below   = (idx_ext < ctrl.count);

  // Insert pulls from the left neighbor, delete from the right one.
  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CMD_INS: begin
        if (at_pos) begin
          entry <= ctrl.val;
        end else if (idx > ctrl.pos) begin
          entry <= left_entry;
        end
      end
      CMD_DEL: begin
        if (idx >= ctrl.pos) begin
          entry <= right_entry;
        end
      end
      CMD_WR: begin
        if (at_pos) begin
          entry <= ctrl.val;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    flags.find_hit = below && (entry == ctrl.val);
    flags.rd_hit   = below && at_pos;
    flags.last_hit = ((idx_ext + CNT_W'(1)) == ctrl.count);
    flags.entry    = entry;
  end

endmodule
`default_nettype wire

>>> rtl/oal_group.sv
`default_nettype none
module oal_group (
  input  wire logic                 clk,
  input  wire oal_pkg::cell_flags_t flags [oal_pkg::GROUP_SIZE],
  output oal_pkg::grp_res_t         res
);
  import oal_pkg::*;

  grp_res_t res_next;

  always_comb begin
    res_next = '0;
    // Walk downward so the lowest matching cell wins.
    for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
      if (flags[i].find_hit) begin
        res_next.found = 1'b1;
        res_next.off   = OFF_W'(i);
      end
    end
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (flags[i].rd_hit) begin
        res_next.rd_val = res_next.rd_val | flags[i].entry;
      end
      if (flags[i].last_hit) begin
        res_next.last_val = res_next.last_val | flags[i].entry;
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

endmodule
`default_nettype wire

>>> rtl/ordered_array_list_core.sv
`default_nettype none
// Requests are accepted only in the idle state; the cell row updates in the
// execute state, the per-group registered reduction in the scan state, and the
// final merge is registered in the finish state once the output is free.
// Reset clears the entry count and the FSM and sets capacity to 64; entry
// contents are not reset and are only read below the count.
module ordered_array_list_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire oal_pkg::req_t        in_data,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output oal_pkg::rsp_t             out_data,
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [2:0]           paddr,
  input  wire logic [31:0]          pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import oal_pkg::*;

  state_t           state, state_next;
  req_t             req;
  logic [CNT_W-1:0] count, count_next;
  logic [CNT_W-1:0] capacity;
  logic [CNT_W-1:0] eff_cap;
  logic [2:0]       op_status, op_status_next;
  cell_ctrl_t       ctrl;
  rsp_t             rsp;
  logic             load_out;

  logic [DATA_W-1:0] ents  [DEPTH];
  cell_flags_t       flags [GROUPS][GROUP_SIZE];
  grp_res_t          gres  [GROUPS];

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CAP_REG_SEL) ? 32'(capacity) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CNT_W'(DEPTH);
    end else if (psel && penable && pwrite && (paddr[2] == CAP_REG_SEL)) begin
      capacity <= pwdata[CNT_W-1:0];
    end
  end

  assign eff_cap = (capacity > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : capacity;

  // Cell row.
  for (genvar g = 0; g < GROUPS; g++) begin : g_grp
    for (genvar c = 0; c < GROUP_SIZE; c++) begin : g_cell
      localparam int K = g * GROUP_SIZE + c;
      logic [DATA_W-1:0] left_w, right_w;
      if (K == 0) begin : g_l0
        assign left_w = '0;
      end else begin : g_ln
        assign left_w = ents[K-1];
      end
      if (K == DEPTH - 1) begin : g_r0
        assign right_w = '0;
      end else begin : g_rn
        assign right_w = ents[K+1];
      end
      oal_cell u_cell (
        .clk         (clk),
        .idx         (IDX_W'(K)),
        .ctrl        (ctrl),
        .left_entry  (left_w),
        .right_entry (right_w),
        .entry       (ents[K]),
        .flags       (flags[g][c])
      );
    end
    oal_group u_group (
      .clk   (clk),
      .flags (flags[g]),
      .res   (gres[g])
    );
  end

  // Request decode; the row only moves in the execute cycle.
  always_comb begin
    logic [CNT_W-1:0] pos_ext;
    pos_ext        = CNT_W'(req.position);
    ctrl.cmd       = CMD_NONE;
    ctrl.pos       = req.position;
    ctrl.val       = req.value;
    ctrl.count     = count;
    count_next     = count;
    op_status_next = ST_OK;
    unique case (req.opcode) inside
      OP_INSERT: begin
        if (count >= eff_cap) begin
          op_status_next = ST_FULL;
        end else if (pos_ext > count) begin
          op_status_next = ST_RANGE;
        end else begin
          ctrl.cmd   = CMD_INS;
          count_next = count + CNT_W'(1);
        end
      end
      OP_DELETE, OP_UPDATE, OP_READ: begin
        if (count == '0) begin
          op_status_next = ST_EMPTY;
        end else if (pos_ext >= count) begin
          op_status_next = ST_RANGE;
        end else if (req.opcode == OP_DELETE) begin
          ctrl.cmd   = CMD_DEL;
          count_next = count - CNT_W'(1);
        end else if (req.opcode == OP_UPDATE) begin
          ctrl.cmd   = CMD_WR;
        end
      end
      default: begin
      end
    endcase
    if (state != S_EXEC) begin
      ctrl.cmd   = CMD_NONE;
      count_next = count;
    end
  end

  // Merge of the group results.
  always_comb begin
    logic             any;
    logic [GRP_W-1:0] gsel;
    logic [OFF_W-1:0] osel;
    logic [DATA_W-1:0] rd_or, last_or;
    any     = 1'b0;
    gsel    = '0;
    osel    = '0;
    rd_or   = '0;
    last_or = '0;
    for (int i = GROUPS - 1; i >= 0; i--) begin
      if (gres[i].found) begin
        any  = 1'b1;
        gsel = GRP_W'(i);
        osel = gres[i].off;
      end
    end
    for (int i = 0; i < GROUPS; i++) begin
      rd_or   = rd_or | gres[i].rd_val;
      last_or = last_or | gres[i].last_val;
    end

    rsp             = '0;
    rsp.status      = op_status;
    rsp.entry_count = count;
    if (req.opcode == OP_FIND) begin
      if (count == '0) begin
        rsp.status = ST_EMPTY;
      end else if (any) begin
        rsp.status      = ST_OK;
        rsp.found_index = {gsel, osel};
      end else begin
        rsp.status = ST_NOTFOUND;
      end
    end
    if (req.opcode == OP_READ && op_status == ST_OK) begin
      rsp.read_value = rd_or;
    end
    if (count != '0) begin
      rsp.first_value = ents[0];
      rsp.last_value  = last_or;
    end
  end

  // Control FSM.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req <= in_data;
    end
    if (state == S_EXEC) begin
      op_status <= op_status_next;
    end
    if (load_out) begin
      out_data <= rsp;
    end
  end

endmodule
`default_nettype wire
